// ----- sv/mti_pkg.sv -----
// package for the tanh network inference block: sizes, word types, tanh table
`timescale 1ns / 1ps
`default_nettype none
package mti_pkg;

  localparam int IN_NODES_D      = 2;
  localparam int HIDDEN_NODES_D  = 5;
  localparam int HIDDEN_LAYERS_D = 2;
  localparam int OUT_NODES_D     = 2;
  localparam int PARAM_DEPTH_D   = 64;

  localparam logic ACT_PARAM   = 1'b0;
  localparam logic ACT_FEATURE = 1'b1;

  typedef struct packed {
    logic               action;
    logic [5:0]         address;
    logic signed [15:0] sample_value;
    logic               run_now;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         out_index;
    logic signed [15:0] out_value;
    logic               out_last;
  } out_word_t;

  // round(4096*tanh(n/4)) for n = 0..33
  function automatic logic [12:0] tanh_tab(input logic [5:0] n);
    logic [12:0] v;
    case (n)
      6'd0:  v = 13'd0;
      6'd1:  v = 13'd1003;
      6'd2:  v = 13'd1893;
      6'd3:  v = 13'd2602;
      6'd4:  v = 13'd3119;
      6'd5:  v = 13'd3475;
      6'd6:  v = 13'd3707;
      6'd7:  v = 13'd3856;
      6'd8:  v = 13'd3949;
      6'd9:  v = 13'd4006;
      6'd10: v = 13'd4041;
      6'd11: v = 13'd4062;
      6'd12: v = 13'd4076;
      6'd13: v = 13'd4084;
      6'd14: v = 13'd4089;
      6'd15: v = 13'd4091;
      6'd16: v = 13'd4093;
      6'd17: v = 13'd4094;
      6'd18: v = 13'd4095;
      6'd19: v = 13'd4095;
      default: v = 13'd4096;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- sv/mti_mac.sv -----
// shared multiply-accumulate unit with round, saturate and tanh stage
`timescale 1ns / 1ps
`default_nettype none
module mti_mac (
  input  wire logic               clk,
  input  wire logic               clr,       // load bias*4096 into accumulator
  input  wire logic               acc_en,    // add registered product
  input  wire logic               mul_en,    // register a*b
  input  wire logic signed [15:0] bias,
  input  wire logic signed [15:0] a,
  input  wire logic signed [15:0] b,
  output logic signed [15:0]      sat_q,     // rounded, saturated sum
  output logic signed [15:0]      tanh_q     // tanh of sat_q
);

  logic signed [31:0] prod_r;
  logic signed [39:0] acc_r;

  // product register
  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= a * b;
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (clr) acc_r <= {{12{bias[15]}}, bias, 12'd0};
    else if (acc_en) acc_r <= acc_r + {{8{prod_r[31]}}, prod_r};
  end

  // round half up and saturate
  logic signed [28:0] rnd;
  always_comb begin
    rnd = 29'((acc_r + 40'sd2048) >>> 12);
    if (rnd > 29'sd32767) sat_q = 16'sd32767;
    else if (rnd < -29'sd32768) sat_q = -16'sd32768;
    else sat_q = rnd[15:0];
  end

  // table tanh with linear interpolation
  logic [16:0] mag;
  logic [5:0]  idx;
  logic [9:0]  frac;
  logic [12:0] lo, hi, y;
  logic [22:0] dp;
  always_comb begin
    mag  = sat_q[15] ? 17'(-$signed({sat_q[15], sat_q})) : 17'(sat_q);
    idx  = (mag[16:10] > 7'd32) ? 6'd32 : mag[15:10];
    frac = mag[9:0];
    lo   = mti_pkg::tanh_tab(idx);
    hi   = mti_pkg::tanh_tab(idx + 6'd1);
    dp   = (hi - lo) * frac + 23'd512;
    y    = lo + 13'(dp >> 10);
    tanh_q = sat_q[15] ? -$signed({3'd0, y}) : $signed({3'd0, y});
  end

endmodule
`default_nettype wire

// ----- sv/mti_seq.sv -----
// sequencer: stores, address generation and result register
`timescale 1ns / 1ps
`default_nettype none
module mti_seq #(
  parameter int IN_NODES      = mti_pkg::IN_NODES_D,
  parameter int HIDDEN_NODES  = mti_pkg::HIDDEN_NODES_D,
  parameter int HIDDEN_LAYERS = mti_pkg::HIDDEN_LAYERS_D,
  parameter int OUT_NODES     = mti_pkg::OUT_NODES_D,
  parameter int PARAM_DEPTH   = mti_pkg::PARAM_DEPTH_D
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mti_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mti_pkg::out_word_t     out_data
);

  localparam int ACT_DEPTH = HIDDEN_NODES * HIDDEN_LAYERS;
  localparam int OFS_WHH = IN_NODES * HIDDEN_NODES;
  localparam int OFS_WHO = OFS_WHH + HIDDEN_NODES * HIDDEN_NODES * (HIDDEN_LAYERS - 1);
  localparam int OFS_BH  = OFS_WHO + HIDDEN_NODES * OUT_NODES;
  localparam int OFS_BO  = OFS_BH + ACT_DEPTH;
  localparam int PAW = $clog2(PARAM_DEPTH);
  localparam int AW  = 12;   // packed address range
  localparam int SW  = 5;    // source counter
  localparam int NW  = 5;    // node counter
  localparam int LW  = 3;    // layer counter
  localparam int ACW = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
  localparam int FW  = (IN_NODES > 1) ? $clog2(IN_NODES) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BIAS = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [LW-1:0] lay_r, lay_nxt;    // HIDDEN_LAYERS means output layer
  logic [NW-1:0] node_r, node_nxt;
  logic [SW-1:0] src_r, src_nxt;

  logic signed [15:0] pmem [PARAM_DEPTH];
  logic signed [15:0] fbuf [IN_NODES];
  logic signed [15:0] amem [ACT_DEPTH];
  logic signed [15:0] pq_r, xq_r;
  logic               pvld_r;

  logic accept;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // layer geometry
  logic [SW-1:0] nsrc;
  logic [NW-1:0] nnode;
  logic is_out;
  always_comb begin
    is_out = (lay_r == LW'(HIDDEN_LAYERS));
    nsrc  = (lay_r == '0) ? SW'(IN_NODES) : SW'(HIDDEN_NODES);
    nnode = is_out ? NW'(OUT_NODES) : NW'(HIDDEN_NODES);
  end

  // packed address of the current weight or bias
  logic [AW-1:0] waddr, baddr, raddr;
  always_comb begin
    if (lay_r == '0)
      waddr = AW'(node_r) * AW'(IN_NODES) + AW'(src_r);
    else if (is_out)
      waddr = AW'(OFS_WHO) + AW'(node_r) * AW'(HIDDEN_NODES) + AW'(src_r);
    else
      waddr = AW'(OFS_WHH) + (AW'(lay_r - 1'b1) * AW'(HIDDEN_NODES) + AW'(node_r))
              * AW'(HIDDEN_NODES) + AW'(src_r);
    baddr = is_out ? AW'(OFS_BO) + AW'(node_r)
                   : AW'(OFS_BH) + AW'(lay_r) * AW'(HIDDEN_NODES) + AW'(node_r);
    raddr = (state_r == S_BIAS) ? baddr : waddr;
  end

  logic [ACW-1:0] aidx, widx;
  always_comb begin
    aidx = ACW'(lay_r - 1'b1) * ACW'(HIDDEN_NODES) + ACW'(src_r);
    widx = ACW'(lay_r) * ACW'(HIDDEN_NODES) + ACW'(node_r);
  end

  // parameter store and operand reads
  always_ff @(posedge clk) begin
    if (accept && in_data.action == mti_pkg::ACT_PARAM &&
        32'(in_data.address) < PARAM_DEPTH)
      pmem[PAW'(in_data.address)] <= in_data.sample_value;
    pq_r   <= pmem[PAW'(raddr)];
    pvld_r <= (32'(raddr) < PARAM_DEPTH);
    if (lay_r == '0) xq_r <= fbuf[FW'(src_r)];
    else xq_r <= amem[aidx];
  end

  // feature buffer
  always_ff @(posedge clk) begin
    if (accept && in_data.action == mti_pkg::ACT_FEATURE &&
        32'(in_data.address) < IN_NODES)
      fbuf[FW'(in_data.address)] <= in_data.sample_value;
  end

  logic signed [15:0] pval, sat_q, tanh_q;
  assign pval = pvld_r ? pq_r : 16'sd0;

  // bias is loaded on the first operand read of a node only
  mti_mac u_mac (
    .clk(clk), .clr(state_r == S_RD && src_r == '0), .acc_en(state_r == S_ACC),
    .mul_en(state_r == S_MUL), .bias(pval), .a(xq_r), .b(pval),
    .sat_q(sat_q), .tanh_q(tanh_q)
  );

  // activation store
  always_ff @(posedge clk) begin
    if (state_r == S_FIN && !is_out) amem[widx] <= tanh_q;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    lay_nxt = lay_r;
    node_nxt = node_r;
    src_nxt = src_r;
    unique case (state_r)
      S_IDLE: if (accept && in_data.run_now) begin
        state_nxt = S_BIAS; lay_nxt = '0; node_nxt = '0; src_nxt = '0;
      end
      S_BIAS: state_nxt = S_RD;
      S_RD:   state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ACC;
      S_ACC:  if (src_r == nsrc - 1'b1) state_nxt = S_FIN;
              else begin
                src_nxt = src_r + 1'b1; state_nxt = S_RD;
              end
      S_FIN:  if (is_out) state_nxt = S_OUT;
              else begin
                src_nxt = '0;
                state_nxt = S_BIAS;
                if (node_r == nnode - 1'b1) begin
                  node_nxt = '0; lay_nxt = lay_r + 1'b1;
                end else node_nxt = node_r + 1'b1;
              end
      S_OUT:  if (!out_stall) begin
                src_nxt = '0;
                if (node_r == nnode - 1'b1) state_nxt = S_IDLE;
                else begin
                  node_nxt = node_r + 1'b1; state_nxt = S_BIAS;
                end
              end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; lay_r <= '0; node_r <= '0; src_r <= '0;
    end else begin
      state_r <= state_nxt; lay_r <= lay_nxt; node_r <= node_nxt; src_r <= src_nxt;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (state_r == S_FIN && is_out) begin
      out_data.out_index <= 3'(node_r);
      out_data.out_value <= sat_q;
      out_data.out_last  <= (node_r == NW'(OUT_NODES - 1));
    end
  end
  assign out_valid = (state_r == S_OUT);

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during result");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACC |-> src_r < nsrc)
    else $error("source counter overran");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> lay_r <= LW'(HIDDEN_LAYERS))
    else $error("layer counter overran");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> is_out)
    else $error("result outside output layer");

endmodule
`default_nettype wire

// ----- sv/mlp_tanh_inference.sv -----
// top level of the tanh network inference block
// Parameter and feature words are taken one a cycle while idle. A word with run_now
// set starts a forward pass on one shared multiply-accumulate unit; the block stalls
// its input until the last result word is taken. Each node has a bias read, then a
// read, a multiply and an accumulate per source weight, then a finish step; each
// output word then waits in the output register until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module mlp_tanh_inference #(
  parameter int IN_NODES      = mti_pkg::IN_NODES_D,
  parameter int HIDDEN_NODES  = mti_pkg::HIDDEN_NODES_D,
  parameter int HIDDEN_LAYERS = mti_pkg::HIDDEN_LAYERS_D,
  parameter int OUT_NODES     = mti_pkg::OUT_NODES_D,
  parameter int PARAM_DEPTH   = mti_pkg::PARAM_DEPTH_D
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mti_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mti_pkg::out_word_t     out_data
);

  mti_seq #(
    .IN_NODES(IN_NODES), .HIDDEN_NODES(HIDDEN_NODES), .HIDDEN_LAYERS(HIDDEN_LAYERS),
    .OUT_NODES(OUT_NODES), .PARAM_DEPTH(PARAM_DEPTH)
  ) u_seq (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// testbench for the tanh network inference block: directed and random parameter and feature words
`timescale 1ns / 1ps
module tb_top;

  localparam int NI = mti_pkg::IN_NODES_D;
  localparam int NH = mti_pkg::HIDDEN_NODES_D;
  localparam int NL = mti_pkg::HIDDEN_LAYERS_D;
  localparam int NO = mti_pkg::OUT_NODES_D;
  localparam int PD = mti_pkg::PARAM_DEPTH_D;
  localparam int OFS_WHH = NI * NH;
  localparam int OFS_WHO = OFS_WHH + NH * NH * (NL - 1);
  localparam int OFS_BH  = OFS_WHO + NH * NO;
  localparam int OFS_BO  = OFS_BH + NH * NL;
  localparam int N_USED  = OFS_BO + NO;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  mti_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  mti_pkg::out_word_t out_data;

  mlp_tanh_inference dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  mti_pkg::in_word_t  pending_words[$];
  mti_pkg::out_word_t expected_nodes[$];
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        errors = 0;

  // predictor state
  logic signed [15:0] weights[PD];
  logic signed [15:0] features[NI];
  logic signed [15:0] acts[NH * NL];

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic signed [63:0] param_at(int a);
    return (a < PD) ? 64'(weights[a]) : 64'sd0;
  endfunction

  // round half up to Q3.12 and saturate
  function automatic logic signed [15:0] round_sat(logic signed [63:0] acc);
    logic signed [63:0] r;
    r = (acc + 64'sd2048) >>> 12;
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < -64'sd32768) r = -64'sd32768;
    return r[15:0];
  endfunction

  function automatic logic signed [15:0] tanh_fixed(logic signed [15:0] s);
    int a, idx, frac, lo, hi, y;
    a = (s < 0) ? -int'(s) : int'(s);
    idx = a >> 10;
    frac = a & 1023;
    if (idx > 32) idx = 32;
    lo = mti_pkg::tanh_tab(6'(idx));
    hi = mti_pkg::tanh_tab(6'(idx + 1));
    y = lo + (((hi - lo) * frac + 512) >>> 10);
    return (s < 0) ? 16'(-y) : 16'(y);
  endfunction

  // add one word to the tail of the pending queue
  task automatic add_pending(mti_pkg::in_word_t w);
    pending_words = {pending_words, w};
  endtask

  // apply one word to the predictor, queue output nodes on a run
  task automatic predict_word(mti_pkg::in_word_t w);
    logic signed [63:0] acc;
    mti_pkg::out_word_t r;
    if (w.action == mti_pkg::ACT_PARAM) begin
      if (int'(w.address) < PD) weights[w.address] = w.sample_value;
    end else if (int'(w.address) < NI) begin
      features[w.address] = w.sample_value;
    end
    if (w.run_now) begin
      for (int j = 0; j < NH; j++) begin
        acc = param_at(OFS_BH + j) * 4096;
        for (int i = 0; i < NI; i++)
          acc += 64'(features[i]) * param_at(j * NI + i);
        acts[j] = tanh_fixed(round_sat(acc));
      end
      for (int l = 1; l < NL; l++)
        for (int j = 0; j < NH; j++) begin
          acc = param_at(OFS_BH + l * NH + j) * 4096;
          for (int i = 0; i < NH; i++)
            acc += 64'(acts[(l - 1) * NH + i]) *
                   param_at(OFS_WHH + ((l - 1) * NH + j) * NH + i);
          acts[l * NH + j] = tanh_fixed(round_sat(acc));
        end
      for (int k = 0; k < NO; k++) begin
        acc = param_at(OFS_BO + k) * 4096;
        for (int j = 0; j < NH; j++)
          acc += 64'(acts[(NL - 1) * NH + j]) * param_at(OFS_WHO + k * NH + j);
        r.out_index = 3'(k);
        r.out_value = round_sat(acc);
        r.out_last = (k == NO - 1);
        expected_nodes = {expected_nodes, r};
      end
    end
  endtask

  function automatic mti_pkg::in_word_t make_word(logic act, int addr, int val, logic run);
    mti_pkg::in_word_t w;
    w.action = act;
    w.address = 6'(addr);
    w.sample_value = 16'(val);
    w.run_now = run;
    return w;
  endfunction

  function automatic int rand_value(int mode);
    case (mode)
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return int'($urandom_range(0, 8191)) - 4096;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // full parameter load then features with run on the last
  task automatic queue_network(int mode);
    for (int a = 0; a < N_USED; a++)
      add_pending(make_word(mti_pkg::ACT_PARAM, a, rand_value(mode), 1'b0));
    for (int i = 0; i < NI; i++)
      add_pending(make_word(mti_pkg::ACT_FEATURE, i, rand_value(mode), i == NI - 1));
  endtask

  // short random sequence: feature/param updates, noise addresses, then a run
  task automatic queue_burst();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1))
        add_pending(make_word(mti_pkg::ACT_FEATURE, $urandom_range(0, 63),
                              rand_value($urandom_range(0, 2)), 1'b0));
      else
        add_pending(make_word(mti_pkg::ACT_PARAM, $urandom_range(0, 63),
                              rand_value($urandom_range(0, 2)), 1'b0));
    end
    add_pending(make_word(1'($urandom_range(0, 1)), $urandom_range(0, 63),
                          rand_value($urandom_range(0, 2)), 1'b1));
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_word(in_data);
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && $urandom_range(1, 100) > idle_pct) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    mti_pkg::out_word_t exp_w;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_nodes.size() == 0) begin
          $display("%0t: unexpected output word %p", $time, out_data);
          errors++;
        end else begin
          exp_w = expected_nodes.pop_front();
          if (out_data.out_index !== exp_w.out_index)
            $display("%0t: out_index expected %0d actual %0d", $time,
                     exp_w.out_index, out_data.out_index);
          if (out_data.out_value !== exp_w.out_value)
            $display("%0t: out_value expected %0d actual %0d", $time,
                     exp_w.out_value, out_data.out_value);
          if (out_data.out_last !== exp_w.out_last)
            $display("%0t: out_last expected %0d actual %0d", $time,
                     exp_w.out_last, out_data.out_last);
          if (out_data !== exp_w) errors++;
        end
      end
      out_stall <= ($urandom_range(1, 100) <= stall_pct);
    end
  end

  // stimulus phases and end of run
  initial begin
    int phase_idle[4] = '{0, 47, 0, 36};
    int phase_stall[4] = '{0, 0, 47, 36};
    for (int i = 0; i < PD; i++) weights[i] = '0;
    for (int i = 0; i < NI; i++) features[i] = '0;
    for (int i = 0; i < NH * NL; i++) acts[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, out-of-range addresses, run on a parameter write
    queue_network(0);
    add_pending(make_word(mti_pkg::ACT_FEATURE, 63, 12345, 1'b0));
    add_pending(make_word(mti_pkg::ACT_PARAM, 63, -32768, 1'b0));
    add_pending(make_word(mti_pkg::ACT_PARAM, 0, 32767, 1'b1));
    add_pending(make_word(mti_pkg::ACT_FEATURE, NI, 1, 1'b1));
    add_pending(make_word(mti_pkg::ACT_FEATURE, 0, -32768, 1'b1));
    add_pending(make_word(mti_pkg::ACT_FEATURE, 0, 0, 1'b1));

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      if (p == 0) queue_network(1);
      for (int b = 0; b < 7; b++) queue_burst();
      if (p == 3) queue_network(2);
      while (pending_words.size() > 0 || in_valid) @(posedge clk);
    end
    idle_pct = 0;
    stall_pct = 0;
    while (expected_nodes.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_nodes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

// ----- files.f -----
sv/mti_pkg.sv
sv/mti_mac.sv
sv/mti_seq.sv
sv/mlp_tanh_inference.sv
tb/tb_top.sv
